// File: hw/rtl/tnsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tnsc_pkg;

   localparam int DIST_W      = 8;
   localparam int LIST_W      = 5;
   localparam int COUNT_OUT_W = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [LIST_W-1:0] LIST_SIZE_RST    = 5'd16;
   localparam logic [DIST_W-1:0] DISTANCE_CAP_RST = 8'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_LIST_SIZE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_CAP = 2'd1;

   localparam logic KIND_OFFER = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic offer;        // insert or replace the candidate
      logic drain_clear;  // latch the count for the drain and empty the store
      logic load_report;  // load a status-only result
      logic load_entry;   // load the head entry and shift the store
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic store_empty;
      logic drain_last;   // one entry left to emit
   } status_type;

endpackage

`default_nettype wire

// File: hw/rtl/tnsc_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tnsc_req_if #(
   parameter int ID_BITS = 24
);
   logic               valid;
   logic               ready;
   logic               kind;
   logic [7:0]         cand_distance;
   logic [ID_BITS-1:0] cand_id;

   modport source (output valid, kind, cand_distance, cand_id, input ready);
   modport sink   (input valid, kind, cand_distance, cand_id, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tnsc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tnsc_rsp_if #(
   parameter int ID_BITS = 24
);
   logic               valid;
   logic               ready;
   logic               entry_valid;
   logic [7:0]         out_distance;
   logic [ID_BITS-1:0] out_id;
   logic [7:0]         threshold;
   logic [4:0]         stored_count;
   logic               is_last;

   modport source (output valid, entry_valid, out_distance, out_id, threshold,
                   stored_count, is_last, input ready);
   modport sink   (input valid, entry_valid, out_distance, out_id, threshold,
                   stored_count, is_last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/top_n_smallest_collector_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Keeps the list_size best (distance, id) pairs offered, smallest distance
// first, ties broken by id; a full store replaces its largest pair only for a
// strictly smaller distance.
// req_chan: kind 0 offers (cand_distance, cand_id), kind 1 drains and clears.
// rsp_chan: one result per offer; a drain returns one result per held entry
// in sorted order (or one status-only result when empty), is_last on the end.
// Every result carries the threshold and the count after the request.
// csr_*: index 0 list_size, index 1 distance_cap; write only while idle.
// An offer's result is loaded into the output register from the report state
// after the store updates; drain entries follow one per cycle while the output
// register is free to take them; the sorted register store updates all cells
// together, and results leave through a single output register.
// The next request is taken while a result still waits in that register; a
// stalled receiver holds the result and stops the drain sequencer.
// Reset empties the store, sets list_size 16 and distance_cap 2; no sweep.

module top_n_smallest_collector_core #(
   parameter int STORE_DEPTH = 16,
   parameter int ID_BITS     = 24
) (
   input  wire                                clock,
   input  wire                                reset,
   tnsc_req_if.sink                           req_chan,
   tnsc_rsp_if.source                         rsp_chan,
   input  wire                                csr_we,
   input  wire [tnsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [tnsc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tnsc_pkg::*;

   cmd_type    cmd;
   status_type status;

   tnsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_kind  (req_chan.kind),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   tnsc_datapath #(
      .STORE_DEPTH (STORE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .cand_distance (req_chan.cand_distance),
      .cand_id       (req_chan.cand_id),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .entry_valid   (rsp_chan.entry_valid),
      .out_distance  (rsp_chan.out_distance),
      .out_id        (rsp_chan.out_id),
      .threshold     (rsp_chan.threshold),
      .stored_count  (rsp_chan.stored_count),
      .is_last       (rsp_chan.is_last)
   );

endmodule

`default_nettype wire

// File: hw/rtl/tnsc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tnsc_datapath #(
   parameter int STORE_DEPTH = 16,
   parameter int ID_BITS     = 24
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  tnsc_pkg::cmd_type                   cmd,
   output tnsc_pkg::status_type                status,
   input  wire  [tnsc_pkg::DIST_W-1:0]         cand_distance,
   input  wire  [ID_BITS-1:0]                  cand_id,
   input  wire                                 csr_we,
   input  wire  [tnsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [tnsc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                entry_valid,
   output logic [tnsc_pkg::DIST_W-1:0]         out_distance,
   output logic [ID_BITS-1:0]                  out_id,
   output logic [tnsc_pkg::DIST_W-1:0]         threshold,
   output logic [tnsc_pkg::COUNT_OUT_W-1:0]    stored_count,
   output logic                                is_last
);
   import tnsc_pkg::*;

   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int LW = (CW > LIST_W) ? CW : LIST_W;
   localparam logic [LW-1:0] DEPTH_L = LW'(STORE_DEPTH);

   // configuration
   logic [LIST_W-1:0] list_size_ff, list_size_in;
   logic [DIST_W-1:0] distance_cap_ff, distance_cap_in;

   // sorted store: cell 0 holds the best entry
   logic [DIST_W-1:0]  dist_ff [STORE_DEPTH];
   logic [DIST_W-1:0]  dist_in [STORE_DEPTH];
   logic [ID_BITS-1:0] id_ff   [STORE_DEPTH];
   logic [ID_BITS-1:0] id_in   [STORE_DEPTH];
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      drain_left_ff, drain_left_in;

   // result register
   logic               entry_valid_ff, entry_valid_in;
   logic [DIST_W-1:0]  out_distance_ff, out_distance_in;
   logic [ID_BITS-1:0] out_id_ff, out_id_in;
   logic [DIST_W-1:0]  threshold_ff, threshold_in;
   logic [COUNT_OUT_W-1:0] stored_count_ff, stored_count_in;
   logic               is_last_ff, is_last_in;

   logic [LW-1:0]      limit;
   logic [LW-1:0]      count_l;
   logic               fits;
   logic               evict;
   logic               do_store;
   logic [CW-1:0]      cnt_base;
   logic [IW-1:0]      worst_idx;
   logic [DIST_W-1:0]  worst_dist;
   logic [DIST_W-1:0]  thresh_now;
   logic [STORE_DEPTH-1:0] goes_before;
   logic [DIST_W-1:0]  sh_dist [STORE_DEPTH];
   logic [ID_BITS-1:0] sh_id   [STORE_DEPTH];

   always_comb begin
      if (list_size_ff == '0) begin
         limit = LW'(1);
      end else if (LW'(list_size_ff) > DEPTH_L) begin
         limit = DEPTH_L;
      end else begin
         limit = LW'(list_size_ff);
      end
   end

   assign count_l    = LW'(count_ff);
   assign worst_idx  = IW'(count_ff - CW'(1));
   assign worst_dist = dist_ff[worst_idx];
   assign fits       = count_l < limit;
   assign evict      = !fits && (count_ff != '0) && (cand_distance < worst_dist);
   assign do_store   = cmd.offer && (fits || evict);
   assign cnt_base   = fits ? count_ff : count_ff - CW'(1);

   always_comb begin
      if (fits) begin
         thresh_now = distance_cap_ff;
      end else begin
         thresh_now = (worst_dist < distance_cap_ff) ? worst_dist : distance_cap_ff;
      end
   end

   // each cell compares itself with the candidate; cells past the base count
   // count as larger so the candidate lands at the first free slot
   always_comb begin
      sh_dist[0] = cand_distance;
      sh_id[0]   = cand_id;
      for (int i = 1; i < STORE_DEPTH; i++) begin
         sh_dist[i] = dist_ff[i-1];
         sh_id[i]   = id_ff[i-1];
      end
      for (int i = 0; i < STORE_DEPTH; i++) begin
         goes_before[i] = (CW'(i) >= cnt_base) ||
                          (cand_distance < dist_ff[i]) ||
                          ((cand_distance == dist_ff[i]) && (cand_id < id_ff[i]));
      end
   end

   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         dist_in[i] = dist_ff[i];
         id_in[i]   = id_ff[i];
         if (do_store && (CW'(i) <= cnt_base) && goes_before[i]) begin
            if (i == 0 || !goes_before[(i == 0) ? 0 : i - 1]) begin
               dist_in[i] = cand_distance;
               id_in[i]   = cand_id;
            end else begin
               dist_in[i] = sh_dist[i];
               id_in[i]   = sh_id[i];
            end
         end else if (cmd.load_entry && i < STORE_DEPTH - 1) begin
            // advance the drain: move everything one cell toward the head
            dist_in[i] = dist_ff[(i < STORE_DEPTH - 1) ? i + 1 : i];
            id_in[i]   = id_ff[(i < STORE_DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      count_in      = count_ff;
      drain_left_in = drain_left_ff;
      if (do_store) begin
         count_in = cnt_base + CW'(1);
      end
      if (cmd.drain_clear) begin
         count_in      = '0;
         drain_left_in = count_ff;
      end
      if (cmd.load_entry) begin
         drain_left_in = drain_left_ff - CW'(1);
      end
   end

   always_comb begin
      list_size_in    = list_size_ff;
      distance_cap_in = distance_cap_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LIST_SIZE:    list_size_in    = csr_wdata[LIST_W-1:0];
            CSR_DISTANCE_CAP: distance_cap_in = csr_wdata[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      entry_valid_in  = entry_valid_ff;
      out_distance_in = out_distance_ff;
      out_id_in       = out_id_ff;
      threshold_in    = threshold_ff;
      stored_count_in = stored_count_ff;
      is_last_in      = is_last_ff;
      if (cmd.load_report) begin
         entry_valid_in  = 1'b0;
         out_distance_in = '0;
         out_id_in       = '0;
         threshold_in    = thresh_now;
         stored_count_in = COUNT_OUT_W'(count_ff);
         is_last_in      = 1'b1;
      end else if (cmd.load_entry) begin
         entry_valid_in  = 1'b1;
         out_distance_in = dist_ff[0];
         out_id_in       = id_ff[0];
         threshold_in    = thresh_now;
         stored_count_in = COUNT_OUT_W'(count_ff);
         is_last_in      = (drain_left_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_size_ff    <= LIST_SIZE_RST;
         distance_cap_ff <= DISTANCE_CAP_RST;
         count_ff        <= '0;
         drain_left_ff   <= '0;
      end else begin
         list_size_ff    <= list_size_in;
         distance_cap_ff <= distance_cap_in;
         count_ff        <= count_in;
         drain_left_ff   <= drain_left_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         dist_ff[i] <= dist_in[i];
         id_ff[i]   <= id_in[i];
      end
      entry_valid_ff  <= entry_valid_in;
      out_distance_ff <= out_distance_in;
      out_id_ff       <= out_id_in;
      threshold_ff    <= threshold_in;
      stored_count_ff <= stored_count_in;
      is_last_ff      <= is_last_in;
   end

   assign status.store_empty = (count_ff == '0);
   assign status.drain_last  = (drain_left_ff == CW'(1));

   assign entry_valid  = entry_valid_ff;
   assign out_distance = out_distance_ff;
   assign out_id       = out_id_ff;
   assign threshold    = threshold_ff;
   assign stored_count = stored_count_ff;
   assign is_last      = is_last_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      do_store |=> count_ff != '0)
      else $error("store empty right after an insert");

   assert property (@(posedge clock) disable iff (reset)
      cmd.drain_clear |=> count_ff == '0)
      else $error("store not cleared by a drain");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_entry |-> drain_left_ff != '0)
      else $error("entry emitted with nothing left to drain");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/tnsc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tnsc_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire                  req_kind,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output tnsc_pkg::cmd_type    cmd,
   input  tnsc_pkg::status_type status
);
   import tnsc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_REPORT = 3'b010,
      S_DRAIN  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      req_fire;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_kind == KIND_DRAIN) begin
                  cmd.drain_clear = 1'b1;
                  state_in = status.store_empty ? S_REPORT : S_DRAIN;
               end else begin
                  cmd.offer = 1'b1;
                  state_in  = S_REPORT;
               end
            end
         end
         S_REPORT: begin
            if (slot_free) begin
               cmd.load_report = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_DRAIN: begin
            if (slot_free) begin
               cmd.load_entry = 1'b1;
               rsp_valid_in   = 1'b1;
               if (status.drain_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request taken while the previous one is in flight");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.load_report || cmd.load_entry) |-> slot_free)
      else $error("result loaded over one not yet taken");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |-> status.store_empty)
      else $error("store holds entries while draining");

   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_kind == KIND_DRAIN && status.store_empty)
         |=> state_ff == S_REPORT)
      else $error("drain of an empty store did not report");
`endif

endmodule

`default_nettype wire

// File: dv/tnsc_result_checker.sv
`timescale 1ns / 1ps

module tnsc_result_checker
   import tnsc_pkg::*;
#(
   parameter int STORE_DEPTH = 16,
   parameter int ID_BITS     = 24
) (
   input  wire                  clock,
   input  wire                  reset,
   tnsc_req_if                  req_mon,
   tnsc_rsp_if                  rsp_mon,
   input  wire                  csr_we,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0] csr_wdata,
   output int                   mismatch_count,
   output int                   pending_results,
   output int                   results_checked
);

   typedef struct packed {
      logic [DIST_W-1:0]  dist_val;
      logic [ID_BITS-1:0] id;
   } kept_pair_t;

   typedef struct packed {
      logic               entry_valid;
      logic [7:0]         out_distance;
      logic [ID_BITS-1:0] out_id;
      logic [7:0]         threshold;
      logic [4:0]         stored_count;
      logic               is_last;
   } rsp_fields_t;

   kept_pair_t  kept [STORE_DEPTH];
   int unsigned kept_n;
   logic [LIST_W-1:0] list_size_q;
   logic [DIST_W-1:0] dist_cap_q;

   rsp_fields_t predicted_results [$];

   // scratch for the sampling block
   rsp_fields_t want;
   rsp_fields_t got;
   kept_pair_t  cand;
   int unsigned drain_n;

   function automatic int unsigned effective_size();
      int unsigned n;
      n = list_size_q;
      if (n < 1) n = 1;
      if (n > STORE_DEPTH) n = STORE_DEPTH;
      return n;
   endfunction

   function automatic logic [7:0] prune_threshold();
      logic [DIST_W-1:0] worst;
      if (kept_n < effective_size() || kept_n == 0) return dist_cap_q;
      worst = kept[kept_n-1].dist_val;
      return (worst < dist_cap_q) ? worst : dist_cap_q;
   endfunction

   function automatic bit pair_precedes(kept_pair_t a, kept_pair_t b);
      if (a.dist_val != b.dist_val) return a.dist_val < b.dist_val;
      return a.id < b.id;
   endfunction

   // slot the pair into the sorted store; room is guaranteed by the caller
   function automatic void insert_pair(kept_pair_t p);
      int unsigned i;
      i = kept_n;
      while (i > 0 && pair_precedes(p, kept[i-1])) begin
         kept[i] = kept[i-1];
         i--;
      end
      kept[i] = p;
      kept_n++;
   endfunction

   function automatic rsp_fields_t status_result(logic valid, logic [7:0] d,
                                                 logic [ID_BITS-1:0] id, logic last);
      rsp_fields_t r;
      r.entry_valid  = valid;
      r.out_distance = d;
      r.out_id       = id;
      r.threshold    = prune_threshold();
      r.stored_count = kept_n[4:0];
      r.is_last      = last;
      return r;
   endfunction

   // append a predicted result at the tail of the queue
   function automatic void queue_result(rsp_fields_t r);
      predicted_results = {predicted_results, r};
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         kept_n          = 0;
         list_size_q     = LIST_SIZE_RST;
         dist_cap_q      = DISTANCE_CAP_RST;
         predicted_results.delete();
         mismatch_count  = 0;
         results_checked = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_LIST_SIZE)
               list_size_q = csr_wdata[LIST_W-1:0];
            else if (csr_index == CSR_DISTANCE_CAP)
               dist_cap_q = csr_wdata[DIST_W-1:0];
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            got.entry_valid  = rsp_mon.entry_valid;
            got.out_distance = rsp_mon.out_distance;
            got.out_id       = rsp_mon.out_id;
            got.threshold    = rsp_mon.threshold;
            got.stored_count = rsp_mon.stored_count;
            got.is_last      = rsp_mon.is_last;
            results_checked++;
            if (predicted_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("[%0t] result with nothing predicted", $realtime);
                  $display("  actual   valid=%0b d=%0d id=%0h thr=%0d cnt=%0d last=%0b",
                           got.entry_valid, got.out_distance, got.out_id,
                           got.threshold, got.stored_count, got.is_last);
               end
            end else begin
               want = predicted_results.pop_front();
               if (got.entry_valid  !== want.entry_valid  ||
                   got.out_distance !== want.out_distance ||
                   got.out_id       !== want.out_id       ||
                   got.threshold    !== want.threshold    ||
                   got.stored_count !== want.stored_count ||
                   got.is_last      !== want.is_last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("[%0t] mismatch", $realtime);
                     $display("  expected valid=%0b d=%0d id=%0h thr=%0d cnt=%0d last=%0b",
                              want.entry_valid, want.out_distance, want.out_id,
                              want.threshold, want.stored_count, want.is_last);
                     $display("  actual   valid=%0b d=%0d id=%0h thr=%0d cnt=%0d last=%0b",
                              got.entry_valid, got.out_distance, got.out_id,
                              got.threshold, got.stored_count, got.is_last);
                  end
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.kind == KIND_OFFER) begin
               cand.dist_val = req_mon.cand_distance;
               cand.id       = req_mon.cand_id;
               if (kept_n < effective_size()) begin
                  insert_pair(cand);
               end else if (kept_n > 0 && cand.dist_val < kept[kept_n-1].dist_val) begin
                  // evict the largest pair held, then slot the newcomer in
                  kept_n--;
                  insert_pair(cand);
               end
               queue_result(status_result(1'b0, '0, '0, 1'b1));
            end else begin
               drain_n = kept_n;
               kept_n  = 0;
               if (drain_n == 0)
                  queue_result(status_result(1'b0, '0, '0, 1'b1));
               else
                  for (int unsigned i = 0; i < drain_n; i++)
                     queue_result(status_result(1'b1, kept[i].dist_val, kept[i].id,
                                                i + 1 == drain_n));
            end
         end

         pending_results = predicted_results.size();
      end
   end

endmodule

// File: dv/top_n_smallest_collector_core_tb.sv
`timescale 1ns / 1ps

module top_n_smallest_collector_core_tb;
   import tnsc_pkg::*;

   localparam int STORE_DEPTH = 16;
   localparam int ID_W        = 24;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 120;
   localparam int RAND_PHASES = 10;
   localparam int PHASE_ITEMS = 44;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bit rsp_idle;
   bit rsp_hold;
   bit req_idle;

   int cycle_count;
   int offers_sent;
   int drains_sent;
   int settings_used;
   logic [7:0] cap_now;

   int mismatch_count;
   int pending_results;
   int results_checked;

   tnsc_req_if #(.ID_BITS(ID_W)) req_chan ();
   tnsc_rsp_if #(.ID_BITS(ID_W)) rsp_chan ();

   top_n_smallest_collector_core #(
      .STORE_DEPTH (STORE_DEPTH),
      .ID_BITS     (ID_W)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tnsc_result_checker #(
      .STORE_DEPTH (STORE_DEPTH),
      .ID_BITS     (ID_W)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results),
      .results_checked (results_checked)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results);
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: random back-pressure per result, or a hard hold while rsp_hold is set
   initial begin : rsp_sink
      int unsigned gap_left;
      gap_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset || rsp_hold) begin
            rsp_chan.ready <= 1'b0;
         end else if (gap_left != 0) begin
            gap_left--;
            rsp_chan.ready <= 1'b0;
         end else if (rsp_chan.valid && rsp_chan.ready && rsp_idle) begin
            gap_left = $urandom_range(0, 7);
            rsp_chan.ready <= (gap_left == 0);
            if (gap_left != 0) gap_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_request(input logic kind, input logic [7:0] cand_dist,
                               input logic [ID_W-1:0] id);
      int unsigned gap;
      gap = req_idle ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.kind          <= kind;
      req_chan.cand_distance <= cand_dist;
      req_chan.cand_id       <= id;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (kind == KIND_OFFER) offers_sent++;
      else drains_sent++;
   endtask

   task automatic offer(input logic [7:0] cand_dist, input logic [ID_W-1:0] id);
      send_request(KIND_OFFER, cand_dist, id);
   endtask

   task automatic drain();
      send_request(KIND_DRAIN, 8'($urandom), ID_W'($urandom));
   endtask

   // drop valid and hold until every predicted result has come back
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic program_regs(input logic [7:0] ls_data, input logic [7:0] cap_data,
                               input bit spare_write);
      csr_we    <= 1'b1;
      csr_index <= CSR_LIST_SIZE;
      csr_wdata <= ls_data;
      @(posedge clock);
      csr_index <= CSR_DISTANCE_CAP;
      csr_wdata <= cap_data;
      @(posedge clock);
      if (spare_write) begin
         csr_index <= $urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO;
         csr_wdata <= CSR_DATA_W'($urandom);
         @(posedge clock);
      end
      csr_we  <= 1'b0;
      cap_now  = cap_data;
      settings_used++;
   endtask

   task automatic random_items(input int n_items, input int drain_odds,
                               input logic [7:0] base);
      int d;
      logic [ID_W-1:0] id;
      for (int k = 0; k < n_items; k++) begin
         if ($urandom_range(0, drain_odds - 1) == 0) begin
            drain();
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2: d = int'($urandom_range(0, 255));
               3, 4, 5: d = int'(cap_now) + int'($urandom_range(0, 6)) - 3;
               default: d = int'(base) + int'($urandom_range(0, 5));
            endcase
            if (d < 0) d = 0;
            if (d > 255) d = 255;
            // small ids make exact ties in (distance, id) likely
            id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom);
            offer(8'(d), id);
         end
      end
   endtask

   initial begin : stimulus
      logic [7:0] ls_data;
      logic [7:0] cap_data;
      logic [7:0] base;
      bit         end_drain;
      bit         pressure;

      reset                  <= 1'b1;
      csr_we                 <= 1'b0;
      csr_index              <= '0;
      csr_wdata              <= '0;
      req_chan.valid         <= 1'b0;
      req_chan.kind          <= KIND_OFFER;
      req_chan.cand_distance <= '0;
      req_chan.cand_id       <= '0;
      rsp_idle               <= 1'b1;
      rsp_hold               <= 1'b0;
      req_idle                = 1'b1;
      cap_now                 = DISTANCE_CAP_RST;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: empty drain, field extremes, equal distances sorted by id
      drain();
      offer(8'd255, 24'hFFFFFF);
      offer(8'd0, 24'h000000);
      offer(8'd7, 24'd5);
      offer(8'd7, 24'd3);
      offer(8'd7, 24'd9);
      drain();
      settle();

      // full store of two: equal distance is refused, a smaller one evicts the largest pair
      program_regs(8'd2, 8'd255, 1'b0);
      offer(8'd10, 24'd1);
      offer(8'd10, 24'd2);
      offer(8'd10, 24'd0);
      offer(8'd9, 24'd7);
      offer(8'd9, 24'd3);
      drain();
      settle();

      // list size zero acts as one, cap of zero
      program_regs(8'd0, 8'd0, 1'b1);
      offer(8'd3, 24'd3);
      offer(8'd2, 24'd8);
      offer(8'd2, 24'd1);
      drain();
      settle();

      // fill three, then shrink the list below the count and replace the largest
      program_regs(8'd3, 8'd255, 1'b0);
      offer(8'd40, 24'd1);
      offer(8'd30, 24'd2);
      offer(8'd20, 24'd3);
      settle();
      program_regs(8'hE1, 8'd255, 1'b1);
      offer(8'd25, 24'd4);
      drain();
      settle();

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         end_drain = 1'b1;
         pressure  = 1'b0;
         case (ph)
            0: begin ls_data = 8'd16;  cap_data = 8'd255; end
            1: begin ls_data = 8'd1;   cap_data = 8'd0;   end_drain = 1'b0; end
            2: begin ls_data = 8'd0;   cap_data = 8'd2;   end
            3: begin ls_data = 8'hFF;  cap_data = 8'd128; end
            4: begin ls_data = 8'd5;   cap_data = 8'($urandom); end
            5: begin ls_data = 8'd16;  cap_data = 8'd3;   end_drain = 1'b0; pressure = 1'b1; end
            6: begin ls_data = 8'd9;   cap_data = 8'd255; end
            7: begin ls_data = 8'd2;   cap_data = 8'd40;  end_drain = 1'b0; end
            8: begin ls_data = 8'($urandom); cap_data = 8'($urandom); end
            default: begin ls_data = 8'($urandom_range(1, 16)); cap_data = 8'($urandom); end
         endcase
         program_regs(ls_data, cap_data, ph % 2 == 1);
         base = 8'($urandom);
         if (base > 8'd250) base = 8'd250;

         if (ph == 3) begin
            req_idle  = 1'b0;
            rsp_idle <= 1'b0;
         end else if (pressure) begin
            req_idle  = 1'b0;
            rsp_idle <= 1'b1;
         end else begin
            req_idle  = 1'b1;
            rsp_idle <= 1'b1;
         end

         if (pressure) begin
            fork
               random_items(PHASE_ITEMS, 20, base);
               begin
                  repeat (8) @(posedge clock);
                  rsp_hold <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  rsp_hold <= 1'b0;
               end
            join
         end else begin
            random_items(PHASE_ITEMS, 16, base);
         end
         if (end_drain) drain();
         settle();
      end

      repeat (8) @(posedge clock);

      $display("Covered %0d offers and %0d drains under %0d register settings,",
               offers_sent, drains_sent, settings_used + 1);
      $display("with %0d results compared against the prediction.", results_checked);
      if (mismatch_count == 0 && pending_results == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/tnsc_pkg.sv
hw/rtl/tnsc_req_if.sv
hw/rtl/tnsc_rsp_if.sv
hw/rtl/tnsc_datapath.sv
hw/rtl/tnsc_ctrl.sv
hw/rtl/top_n_smallest_collector_core.sv
dv/tnsc_result_checker.sv
dv/top_n_smallest_collector_core_tb.sv
